// ===== sv/fsv_pkg.sv =====
// ----------------------------------------------------------------------------
// fsv_pkg
// Shared types, character codes and helper functions for the float string
// validator: character class record, infinity tracker, saturating increment.
// ----------------------------------------------------------------------------
package fsv_pkg;

  // ASCII codes used by the checker
  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrDot   = 8'h2E;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrUpA   = 8'h41;
  localparam logic [7:0] ChrUpE   = 8'h45;
  localparam logic [7:0] ChrUpF   = 8'h46;
  localparam logic [7:0] ChrUpI   = 8'h49;
  localparam logic [7:0] ChrUpN   = 8'h4E;
  localparam logic [7:0] ChrUpP   = 8'h50;
  localparam logic [7:0] ChrUpT   = 8'h54;
  localparam logic [7:0] ChrUpX   = 8'h58;
  localparam logic [7:0] ChrUpY   = 8'h59;
  localparam logic [7:0] ChrUpZ   = 8'h5A;
  localparam logic [7:0] ChrLoA   = 8'h61;
  localparam logic [7:0] ChrLoZ   = 8'h7A;
  localparam logic [7:0] CaseGap  = 8'h20;

  // Infinity pattern positions
  localparam logic [3:0] PosStart = 4'd0;
  localparam logic [3:0] PosSign  = 4'd1;
  localparam logic [3:0] PosI     = 4'd2;
  localparam logic [3:0] PosInf   = 4'd4;
  localparam logic [3:0] PosLast  = 4'd8;
  localparam logic [3:0] PosFull  = 4'd9;
  localparam logic [3:0] PosDead  = 4'd15;

  // Saturation limit for the P and E counters
  localparam logic [1:0] CntSat = 2'd2;

  // Classification of one character
  typedef struct packed {
    logic       is_nul;
    logic       is_space;
    logic       is_alnum;
    logic       allowed;
    logic [7:0] upper;
  } chr_class_t;

  // Character expected after pattern position pos (positions 2..8)
  function automatic logic [7:0] inf_tail_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd2:    ch = ChrUpN;
      4'd3:    ch = ChrUpF;
      4'd4:    ch = ChrUpI;
      4'd5:    ch = ChrUpN;
      4'd6:    ch = ChrUpI;
      4'd7:    ch = ChrUpT;
      4'd8:    ch = ChrUpY;
      default: ch = ChrNul;
    endcase
    return ch;
  endfunction

  // Advance the [sign]INF[INITY] tracker by one upper-cased character
  function automatic logic [3:0] next_inf_pos(input logic [3:0] pos, input logic [7:0] u);
    logic [3:0] nxt;
    nxt = PosDead;
    if (pos == PosStart && (u == ChrPlus || u == ChrMinus)) begin
      nxt = PosSign;
    end else if (pos <= PosSign) begin
      nxt = (u == ChrUpI) ? PosI : PosDead;
    end else if (pos >= PosI && pos <= PosLast) begin
      nxt = (u == inf_tail_char(pos)) ? pos + 4'd1 : PosDead;
    end
    return nxt;
  endfunction

  // Saturating increment
  function automatic logic [1:0] sat_inc(input logic [1:0] v);
    return (v >= CntSat) ? CntSat : v + 2'd1;
  endfunction

endpackage

// ===== sv/fsv_char_class.sv =====
// ----------------------------------------------------------------------------
// fsv_char_class
// Classifies one input byte: terminator, whitespace, alphanumeric, member of
// the allowed number alphabet, and its upper-case form.
// ----------------------------------------------------------------------------
module fsv_char_class (
  input  logic [7:0]          chr,
  output fsv_pkg::chr_class_t cls
);
  import fsv_pkg::*;

  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] upper;

  // Basic ranges
  assign is_digit = (chr >= ChrZero) && (chr <= ChrNine);
  assign is_upper = (chr >= ChrUpA)  && (chr <= ChrUpZ);
  assign is_lower = (chr >= ChrLoA)  && (chr <= ChrLoZ);
  assign upper    = is_lower ? chr - CaseGap : chr;

  // Pack the classification
  always_comb begin
    cls.is_nul   = (chr == ChrNul);
    cls.is_space = (chr == ChrSpace) || ((chr >= ChrTab) && (chr <= ChrCr));
    cls.is_alnum = is_digit || is_upper || is_lower;
    cls.allowed  = ((upper >= ChrZero) && (upper <= ChrNine)) ||
                   ((upper >= ChrUpA) && (upper <= ChrUpF)) ||
                   (upper == ChrDot) || (upper == ChrPlus) || (upper == ChrMinus) ||
                   (upper == ChrUpX) || (upper == ChrUpP);
    cls.upper    = upper;
  end

endmodule

// ===== sv/float_string_validator.sv =====
// ----------------------------------------------------------------------------
// float_string_validator
// Checks a number string streamed one byte per request, NUL terminated, and
// delivers one verdict (valid, infinity) per string.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_ready, in_character[7:0]  | input
//   out     | out_valid, out_ready, out_is_valid,    | output
//           | out_is_infinity                        |
//
// in_ready drops only while a verdict is held by out_ready low; otherwise
// one byte is accepted per cycle. Per-string flags update in the cycle the
// byte is taken. The verdict is registered for the cycle after the NUL is
// accepted. Synchronous active-low reset clears the flags and result slot.
// ----------------------------------------------------------------------------
module float_string_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_valid,
  output logic       out_is_infinity
);
  import fsv_pkg::*;

  chr_class_t cls;
  logic       in_fire;
  logic       ok;

  logic       lead_r,     lead_nxt;
  logic       seen_r,     seen_nxt;
  logic       badc_r,     badc_nxt;
  logic       badp_r,     badp_nxt;
  logic [1:0] pcnt_r,     pcnt_nxt;
  logic [1:0] ecnt_r,     ecnt_nxt;
  logic [3:0] pos_r,      pos_nxt;
  logic       infc_r,     infc_nxt;
  logic       ovalid_r,   ovalid_nxt;
  logic       oisval_r,   oisval_nxt;
  logic       oisinf_r,   oisinf_nxt;

  fsv_char_class u_class (
    .chr (in_character),
    .cls (cls)
  );

  // Handshake: result register parts the two sides
  assign in_ready = !ovalid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Verdict from the flags gathered so far
  assign ok = seen_r && (infc_r ||
              (!badc_r && (pcnt_r <= 2'd1) && ((pcnt_r != 2'd0) || (ecnt_r <= 2'd1))));

  // Flag and result update
  always_comb begin
    lead_nxt   = lead_r;
    seen_nxt   = seen_r;
    badc_nxt   = badc_r;
    badp_nxt   = badp_r;
    pcnt_nxt   = pcnt_r;
    ecnt_nxt   = ecnt_r;
    pos_nxt    = pos_r;
    infc_nxt   = infc_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oisval_nxt = oisval_r;
    oisinf_nxt = oisinf_r;
    if (in_fire) begin
      if (cls.is_nul) begin
        ovalid_nxt = 1'b1;
        oisval_nxt = ok;
        oisinf_nxt = seen_r && infc_r;
        lead_nxt   = 1'b1;
        seen_nxt   = 1'b0;
        badc_nxt   = 1'b0;
        badp_nxt   = 1'b0;
        pcnt_nxt   = 2'd0;
        ecnt_nxt   = 2'd0;
        pos_nxt    = PosStart;
        infc_nxt   = 1'b0;
      end else if (!(lead_r && cls.is_space)) begin
        lead_nxt = 1'b0;
        pos_nxt  = next_inf_pos(pos_r, cls.upper);
        if (cls.is_alnum) begin
          seen_nxt = 1'b1;
          if (badp_r || !cls.allowed) begin
            badc_nxt = 1'b1;
          end
          badp_nxt = 1'b0;
          if (cls.upper == ChrUpP) begin
            pcnt_nxt = sat_inc(pcnt_r);
          end
          if (cls.upper == ChrUpE) begin
            ecnt_nxt = sat_inc(ecnt_r);
          end
          infc_nxt = (pos_nxt == PosInf) || (pos_nxt == PosFull);
        end else if (!cls.allowed) begin
          badp_nxt = 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= 1'b1;
      seen_r   <= 1'b0;
      badc_r   <= 1'b0;
      badp_r   <= 1'b0;
      pcnt_r   <= 2'd0;
      ecnt_r   <= 2'd0;
      pos_r    <= PosStart;
      infc_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      lead_r   <= lead_nxt;
      seen_r   <= seen_nxt;
      badc_r   <= badc_nxt;
      badp_r   <= badp_nxt;
      pcnt_r   <= pcnt_nxt;
      ecnt_r   <= ecnt_nxt;
      pos_r    <= pos_nxt;
      infc_r   <= infc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    oisval_r <= oisval_nxt;
    oisinf_r <= oisinf_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_is_valid    = oisval_r;
  assign out_is_infinity = oisinf_r;

  // A terminator always leaves a verdict in the result slot
  a_nul_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cls.is_nul) |=> ovalid_r)
    else $error("terminator accepted without a verdict");

  // A terminator restarts the string flags
  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cls.is_nul) |=> (lead_r && !seen_r && !badc_r && pos_r == PosStart))
    else $error("string flags not restarted after terminator");

  // An infinity verdict is always a valid one
  a_inf_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (!oisinf_r || oisval_r))
    else $error("infinity reported on an invalid string");

  // Counters saturate
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r <= CntSat) && (ecnt_r <= CntSat))
    else $error("P or E counter beyond saturation");

endmodule

// ===== sim/fsv_checker.sv =====
// ----------------------------------------------------------------------------
// fsv_checker
// Watches both channels of the float string validator. Every character
// request taken at the input updates a private copy of the per-string flags.
// A NUL turns the flags into an expected verdict, which is queued. Every
// verdict taken at the output is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module fsv_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_is_valid,
  input  logic       out_is_infinity,
  output int         fail_count,
  output int         verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsv_pkg::*;

  localparam logic [63:0] InfWord = "INFINITY";
  localparam int          ShownMismatches = 10;

  typedef struct packed {
    logic ok;
    logic inf;
  } verdict_t;

  verdict_t expected_verdicts[$];

  // Per-string flags of the predictor
  logic       skipping_ws;
  logic       have_alnum;
  logic       text_bad;
  logic       junk_pending;
  logic [1:0] p_seen;
  logic [1:0] e_seen;
  logic [3:0] inf_pos;
  logic       inf_ok;

  task automatic clear_flags();
    skipping_ws  = 1'b1;
    have_alnum   = 1'b0;
    text_bad     = 1'b0;
    junk_pending = 1'b0;
    p_seen       = 2'd0;
    e_seen       = 2'd0;
    inf_pos      = PosStart;
    inf_ok       = 1'b0;
  endtask

  // Fold one character into the flags; a NUL queues the verdict
  task automatic predict_verdict(input logic [7:0] ch);
    logic [7:0] u;
    logic       alnum;
    logic       in_set;
    logic       ws;
    int         sh;
    verdict_t   v;
    if (ch == ChrNul) begin
      v.ok  = have_alnum && (inf_ok ||
              (!text_bad && p_seen <= 2'd1 && (p_seen != 2'd0 || e_seen <= 2'd1)));
      v.inf = have_alnum && inf_ok;
      expected_verdicts.push_back(v);
      clear_flags();
      return;
    end
    ws = (ch == ChrSpace) || (ch >= ChrTab && ch <= ChrCr);
    if (skipping_ws && ws) begin
      return;
    end
    skipping_ws = 1'b0;
    u      = (ch >= ChrLoA && ch <= ChrLoZ) ? ch - CaseGap : ch;
    alnum  = (u >= ChrZero && u <= ChrNine) || (u >= ChrUpA && u <= ChrUpZ);
    in_set = (u >= ChrZero && u <= ChrNine) || (u >= ChrUpA && u <= ChrUpF) ||
             u == ChrDot || u == ChrPlus || u == ChrMinus || u == ChrUpX || u == ChrUpP;
    // walk the [sign]INF[INITY] pattern
    if (inf_pos == PosStart && (u == ChrPlus || u == ChrMinus)) begin
      inf_pos = PosSign;
    end else if (inf_pos <= PosSign) begin
      inf_pos = (u == ChrUpI) ? PosI : PosDead;
    end else if (inf_pos <= PosLast) begin
      sh      = 8 * (9 - int'(inf_pos)) - 1;
      inf_pos = (u == InfWord[sh -: 8]) ? inf_pos + 4'd1 : PosDead;
    end else begin
      inf_pos = PosDead;
    end
    if (alnum) begin
      have_alnum = 1'b1;
      if (junk_pending || !in_set) begin
        text_bad = 1'b1;
      end
      junk_pending = 1'b0;
      if (u == ChrUpP && p_seen < 2'd2) begin
        p_seen = p_seen + 2'd1;
      end
      if (u == ChrUpE && e_seen < 2'd2) begin
        e_seen = e_seen + 2'd1;
      end
      inf_ok = (inf_pos == PosInf || inf_pos == PosFull);
    end else if (!in_set) begin
      junk_pending = 1'b1;
    end
  endtask

  // Compare taken verdicts, then absorb the taken character
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      clear_flags();
      expected_verdicts.delete();
      fail_count       = 0;
      verdicts_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= ShownMismatches) begin
            $display("%0t: verdict with none expected: is_valid=%0b is_infinity=%0b",
                     $time, out_is_valid, out_is_infinity);
          end
        end else begin
          want = expected_verdicts.pop_front();
          if (out_is_valid !== want.ok || out_is_infinity !== want.inf) begin
            fail_count++;
            if (fail_count <= ShownMismatches) begin
              $display("%0t: mismatch: is_valid exp %0b got %0b, is_infinity exp %0b got %0b",
                       $time, want.ok, out_is_valid, want.inf, out_is_infinity);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_verdict(in_character);
      end
      verdicts_pending = expected_verdicts.size();
    end
  end

endmodule

// ===== sim/tb_float_string_validator.sv =====
// ----------------------------------------------------------------------------
// tb_float_string_validator
// Streams number strings into the validator: a few hand-picked strings, a
// back-pressure phase, then random strings (numbers, infinities, E/P heavy
// text and raw bytes) with whitespace and junk around them. Both sides idle
// at random. The checker beside the block predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tb_float_string_validator;
  timeunit 1ns;
  timeprecision 1ps;
  import fsv_pkg::*;

  localparam int HoldCycles  = 80;
  localparam int CycleLimit  = 400000;
  localparam int RandomChars = 1750;
  localparam int SettleCycles = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_character;
  logic       out_valid;
  logic       out_ready;
  logic       out_is_valid;
  logic       out_is_infinity;
  int         fail_count;
  int         verdicts_pending;

  logic [7:0] word_q[$];
  bit         tx_calm;
  bit         rx_calm;
  bit         hold_req;
  int         sent_chars;
  int         cycle_count;

  float_string_validator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_character    (in_character),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_valid    (out_is_valid),
    .out_is_infinity (out_is_infinity)
  );

  fsv_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_valid     (out_is_valid),
    .out_is_infinity  (out_is_infinity),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Random letter case
  function automatic logic [7:0] rand_case(input logic [7:0] ch);
    if (ch >= ChrUpA && ch <= ChrUpZ && $urandom_range(0, 1) == 1) begin
      return ch + CaseGap;
    end
    return ch;
  endfunction

  // One character of 0-9 . + - A-F X P, either case
  function automatic logic [7:0] pick_number_char();
    int v;
    v = $urandom_range(0, 20);
    if (v < 10) begin
      return ChrZero + v[7:0];
    end else if (v < 16) begin
      return rand_case(ChrUpA + v[7:0] - 8'd10);
    end
    case (v)
      16:      return ChrDot;
      17:      return ChrPlus;
      18:      return ChrMinus;
      19:      return rand_case(ChrUpX);
      default: return rand_case(ChrUpP);
    endcase
  endfunction

  // Any non-NUL byte that is not a letter or digit
  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while ((b >= ChrZero && b <= ChrNine) || (b >= ChrUpA && b <= ChrUpZ) ||
               (b >= ChrLoA && b <= ChrLoZ));
    return b;
  endfunction

  function automatic logic [7:0] pick_space();
    int v;
    v = $urandom_range(0, 5);
    return (v == 5) ? ChrSpace : ChrTab + v[7:0];
  endfunction

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      word_q.push_back(s[i]);
    end
  endtask

  // Offer one character request and wait until it is taken
  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_chars++;
    @(negedge clk);
  endtask

  // Send the queued text and its terminator
  task automatic send_text();
    foreach (word_q[i]) begin
      send_char(word_q[i]);
    end
    send_char(ChrNul);
    word_q.delete();
  endtask

  // Stop offering and let every queued verdict come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdicts_pending != 0) @(negedge clk);
  endtask

  // Build one random string into the text queue
  task automatic make_word(input int kind);
    int n;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) begin
      word_q.push_back(pick_space());
    end
    case (kind)
      0, 1, 2, 3: begin
        if ($urandom_range(0, 3) == 0) begin
          word_q.push_back(ChrZero);
          word_q.push_back(rand_case(ChrUpX));
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
          // junk inside the text spoils it only once a letter or digit follows
          if ($urandom_range(0, 11) == 0) begin
            word_q.push_back(pick_junk());
          end
          word_q.push_back(pick_number_char());
        end
      end
      4, 5: begin
        if ($urandom_range(0, 1) == 1) begin
          word_q.push_back($urandom_range(0, 1) ? ChrPlus : ChrMinus);
        end
        word_q.push_back(rand_case(ChrUpI));
        word_q.push_back(rand_case(ChrUpN));
        word_q.push_back(rand_case(ChrUpF));
        if ($urandom_range(0, 1) == 1) begin
          word_q.push_back(rand_case(ChrUpI));
          word_q.push_back(rand_case(ChrUpN));
          word_q.push_back(rand_case(ChrUpI));
          word_q.push_back(rand_case(ChrUpT));
          word_q.push_back(rand_case(ChrUpY));
        end
        if ($urandom_range(0, 5) == 0) begin
          void'(word_q.pop_back());
        end
        if ($urandom_range(0, 5) == 0) begin
          word_q.push_back(pick_number_char());
        end
      end
      6, 7: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       word_q.push_back(rand_case(ChrUpE));
            1:       word_q.push_back(rand_case(ChrUpP));
            default: word_q.push_back(pick_number_char());
          endcase
        end
      end
      default: begin
        n = $urandom_range(0, 8);
        repeat (n) word_q.push_back(8'($urandom_range(1, 255)));
      end
    endcase
    // trailing junk is dropped by the block
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) word_q.push_back(pick_junk());
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if ($urandom_range(0, 15) == 0) begin
        rx_calm = !rx_calm;
      end
      gap = rx_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Request side and verdict
  initial begin
    int strings;
    in_valid     = 1'b0;
    in_character = 8'd0;
    rst_n        = 1'b0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_req     = 1'b0;
    sent_chars   = 0;
    strings      = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty and blank text
    send_text();
    load_text(" ");
    word_q.push_back(ChrTab);
    send_text();
    // infinities, plain and signed
    load_text("inf");
    send_text();
    load_text("-Infinity");
    send_text();
    // high bytes: trailing one is dropped, inner one spoils the text
    load_text("1");
    word_q.push_back(8'hFF);
    send_text();
    load_text("p");
    word_q.push_back(8'h80);
    load_text("P");
    send_text();
    load_text("Xp");
    send_text();
    // two E without P
    load_text("e1E");
    send_text();

    // long receiver hold-off while requests keep coming
    tx_calm  = 1'b1;
    hold_req = 1'b1;
    repeat (8) begin
      load_text("7");
      send_text();
    end
    tx_calm = 1'b0;
    wait_drained();

    sent_chars = 0;
    while (sent_chars < RandomChars) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_calm = !tx_calm;
      end
      make_word($urandom_range(0, 9));
      send_text();
      strings++;
      if (strings % 50 == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fsv_pkg.sv
sv/fsv_char_class.sv
sv/float_string_validator.sv
sim/fsv_checker.sv
sim/tb_float_string_validator.sv
